@@ hdl/p2c_pkg.sv @@
// Shared types, constants and helpers for the planar-to-chunky palette scaler.
// No dependencies; imported by p2c_if, p2c_seq, p2c_out and the top level.
`default_nettype none

package p2c_pkg;

  // geometry of one pixel group and of the palette
  localparam int PIXELS        = 8;
  localparam int PX_W          = 3;
  localparam int PLANE_BYTES_W = 64;
  localparam int IDX_W         = 8;
  localparam int PAL_DEPTH     = 256;
  localparam int COLOR_W       = 12;
  localparam int CHAN_W        = 8;
  localparam logic [PX_W-1:0] PX_LAST = 3'd7;

  // defaults of the top-level parameters
  localparam int NUM_PLANES_DEF = 8;
  localparam int MAX_SCALE_DEF  = 8;

  // configuration port
  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;

  typedef enum logic [1:0] {
    REG_SCALE        = 2'd0,
    REG_PLANE_ENABLE = 2'd1,
    REG_PLANE_COUNT  = 2'd2
  } cfg_reg_e;

  // register reset values
  localparam logic [3:0] SCALE_RST        = 4'd1;
  localparam logic [7:0] PLANE_ENABLE_RST = 8'hff;
  localparam logic [3:0] PLANE_COUNT_RST  = 4'd4;

  // item opcodes
  localparam logic OP_PAL_WRITE = 1'b0;
  localparam logic OP_CONVERT   = 1'b1;

  typedef struct packed {
    logic [3:0] scale;
    logic [7:0] plane_enable;
    logic [3:0] plane_count;
  } p2c_cfg_t;

  // one palette read issued by the sequencer
  typedef struct packed {
    logic valid;
    logic last;
  } p2c_issue_t;

  // rgb4 nibble to 8-bit channel by replication
  function automatic logic [CHAN_W-1:0] widen_nib(input logic [3:0] nib);
    return {nib, nib};
  endfunction

endpackage

`default_nettype wire

@@ hdl/p2c_if.sv @@
// Stream interfaces of the palette scaler: input items and result pixels.
// Depends on p2c_pkg for field widths.
`default_nettype none

interface p2c_in_if
  import p2c_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic                     opcode;
  logic [PLANE_BYTES_W-1:0] plane_bytes;
  logic [IDX_W-1:0]         palette_index;
  logic [COLOR_W-1:0]       palette_color;

  modport source (output valid, opcode, plane_bytes, palette_index, palette_color,
                  input ready);
  modport sink   (input valid, opcode, plane_bytes, palette_index, palette_color,
                  output ready);
endinterface

interface p2c_out_if
  import p2c_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] red;
  logic [CHAN_W-1:0] green;
  logic [CHAN_W-1:0] blue;
  logic              last;

  modport source (output valid, red, green, blue, last, input ready);
  modport sink   (input valid, red, green, blue, last, output ready);
endinterface

`default_nettype wire

@@ hdl/p2c_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies; read during write to the same address returns old data.
`default_nettype none

module p2c_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port, holds while re_i is low
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ hdl/p2c_seq.sv @@
// Input stage and pixel sequencer: takes items, writes the palette, and walks
// the eight pixels of a group times the repeat count. Depends on p2c_pkg, p2c_if.
`default_nettype none

module p2c_seq
  import p2c_pkg::*;
#(
  parameter int NUM_PLANES = NUM_PLANES_DEF,
  parameter int MAX_SCALE  = MAX_SCALE_DEF
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  p2c_in_if.sink            in_i,
  input  wire p2c_cfg_t     cfg_i,
  input  wire logic         issue_ready_i,
  output      p2c_issue_t   issue_o,
  output      logic         pal_we_o,
  output      logic [IDX_W-1:0]   pal_waddr_o,
  output      logic [COLOR_W-1:0] pal_wdata_o,
  output      logic         pal_re_o,
  output      logic [IDX_W-1:0]   pal_raddr_o
);

  localparam int REP_W = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;

  logic                     grp_valid_q;
  logic [PLANE_BYTES_W-1:0] planes_q;
  logic [PX_W-1:0]          px_q, px_d;
  logic [REP_W-1:0]         rep_q, rep_d;
  logic [3:0]               reps;
  logic [3:0]               reps_m1;
  logic                     rep_end;
  logic                     issue;
  logic                     done;
  logic                     accept;
  logic [IDX_W-1:0]         idx;

  // clamp the repeat count to 1..MAX_SCALE
  always_comb begin
    if (cfg_i.scale == 4'd0) begin
      reps = 4'd1;
    end else if (cfg_i.scale > 4'(MAX_SCALE)) begin
      reps = 4'(MAX_SCALE);
    end else begin
      reps = cfg_i.scale;
    end
  end
  assign reps_m1 = reps - 4'd1;

  assign rep_end = (4'(rep_q) == reps_m1);
  assign issue   = grp_valid_q && issue_ready_i;
  assign done    = issue && rep_end && (px_q == PX_LAST);

  // input handshake
  assign in_i.ready = !grp_valid_q || done;
  assign accept     = in_i.valid && in_i.ready;

  // palette write goes straight to the ram
  assign pal_we_o    = accept && (in_i.opcode == OP_PAL_WRITE);
  assign pal_waddr_o = in_i.palette_index;
  assign pal_wdata_o = in_i.palette_color;

  // palette index of the current pixel, msb of each plane byte first
  always_comb begin
    logic [7:0] pb;
    idx = '0;
    pb  = '0;
    for (int n = 0; n < NUM_PLANES; n++) begin
      pb     = planes_q[8*n +: 8];
      idx[n] = pb[~px_q] & cfg_i.plane_enable[n] & (4'(n) < cfg_i.plane_count);
    end
  end

  assign pal_re_o      = issue;
  assign pal_raddr_o   = idx;
  assign issue_o.valid = issue;
  assign issue_o.last  = done;

  // pixel and repeat counters
  always_comb begin
    px_d  = px_q;
    rep_d = rep_q;
    if (accept && (in_i.opcode == OP_CONVERT)) begin
      px_d  = '0;
      rep_d = '0;
    end else if (issue) begin
      if (rep_end) begin
        rep_d = '0;
        px_d  = px_q + 3'd1;
      end else begin
        rep_d = rep_q + REP_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grp_valid_q <= 1'b0;
      px_q        <= '0;
      rep_q       <= '0;
    end else begin
      px_q  <= px_d;
      rep_q <= rep_d;
      if (accept && (in_i.opcode == OP_CONVERT)) begin
        grp_valid_q <= 1'b1;
      end else if (done) begin
        grp_valid_q <= 1'b0;
      end
    end
  end

  // group payload
  always_ff @(posedge clk_i) begin
    if (accept && (in_i.opcode == OP_CONVERT)) begin
      planes_q <= in_i.plane_bytes;
    end
  end

`ifndef SYNTH
  // a palette write never lands while a group still has reads to issue
  a_wr_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pal_we_o |-> (!grp_valid_q || done))
    else $error("palette write overtook a pending group");

  // counters hold while the read side stalls
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (grp_valid_q && !issue_ready_i) |=> ($stable(px_q) && $stable(rep_q)))
    else $error("pixel counters moved during a stall");

  // repeat counter stays inside the clamped repeat count
  a_rep_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    grp_valid_q |-> (4'(rep_q) <= reps_m1))
    else $error("repeat counter out of range");
`endif

endmodule

`default_nettype wire

@@ hdl/p2c_out.sv @@
// Read-data stage and result register: widens the palette color and holds
// each beat until the receiver takes it. Depends on p2c_pkg, p2c_if.
`default_nettype none

module p2c_out
  import p2c_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire p2c_issue_t         issue_i,
  output      logic               issue_ready_o,
  input  wire logic [COLOR_W-1:0] rdata_i,
  p2c_out_if.source               out_o
);

  logic              rd_valid_q;
  logic              rd_last_q;
  logic              res_valid_q;
  logic              res_last_q;
  logic [CHAN_W-1:0] red_q, green_q, blue_q;
  logic              res_take;

  assign res_take      = !res_valid_q || out_o.ready;
  assign issue_ready_o = !rd_valid_q || res_take;

  // control of the read stage and the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (issue_i.valid) begin
        rd_valid_q <= 1'b1;
      end else if (res_take) begin
        rd_valid_q <= 1'b0;
      end
      if (res_take) begin
        res_valid_q <= rd_valid_q;
      end
    end
  end

  // payloads
  always_ff @(posedge clk_i) begin
    if (issue_i.valid) begin
      rd_last_q <= issue_i.last;
    end
    if (res_take && rd_valid_q) begin
      res_last_q <= rd_last_q;
      red_q      <= widen_nib(rdata_i[11:8]);
      green_q    <= widen_nib(rdata_i[7:4]);
      blue_q     <= widen_nib(rdata_i[3:0]);
    end
  end

  assign out_o.valid = res_valid_q;
  assign out_o.last  = res_last_q;
  assign out_o.red   = red_q;
  assign out_o.green = green_q;
  assign out_o.blue  = blue_q;

`ifndef SYNTH
  // a read only issues when the read stage can move on
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue_i.valid |-> issue_ready_o)
    else $error("palette read issued into a full stage");

  // a held read beat is not dropped while the result register stalls
  a_rd_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_valid_q && !res_take) |=> (rd_valid_q && $stable(rd_last_q)))
    else $error("read beat lost during a stall");
`endif

endmodule

`default_nettype wire

@@ hdl/planar_to_chunky_palette_scaler.sv @@
// Planar-to-chunky palette scaler: bitplane groups in, rgb888 pixels out.
// Top level; depends on p2c_pkg, p2c_if, p2c_ram, p2c_seq and p2c_out.
//
// Usage:
//   in_i carries one beat per item. opcode 0 writes palette_color into the
//   256-entry palette at palette_index and gives no result. opcode 1
//   converts a group of eight pixels, one byte per plane in plane_bytes,
//   msb first; each pixel leaves on out_o scale times, with scale clamped
//   to 1..MAX_SCALE, and the final beat of the group has last set.
//   Registers on the apb port: scale at 0x0, plane_enable at 0x4,
//   plane_count at 0x8; write them only while the block is idle.
//   Path: the first pixel of a group passes the sequencer, the palette
//   read and the result register after the group is accepted.
//   Throughput: one output beat per cycle while out_o.ready stays high;
//   the next item is taken in the cycle the last palette read of the
//   current group issues.
//   Reset: registers return to scale 1, all planes enabled, four planes;
//   the pipeline empties. Palette entries are undefined until written.
//   Stall: a low out_o.ready holds the result beat, then the read stage,
//   then the sequencer; in_i.ready drops while a group is still pending.
`default_nettype none

module planar_to_chunky_palette_scaler
  import p2c_pkg::*;
#(
  parameter int NUM_PLANES = NUM_PLANES_DEF,
  parameter int MAX_SCALE  = MAX_SCALE_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  p2c_in_if.sink                 in_i,
  p2c_out_if.source              out_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [CFG_DW-1:0] pwdata,
  output      logic [CFG_DW-1:0] prdata,
  output      logic              pready
);

  logic [3:0]         scale_q;
  logic [7:0]         plane_enable_q;
  logic [3:0]         plane_count_q;
  logic               cfg_wr;
  p2c_cfg_t           cfg;
  p2c_issue_t         issue;
  logic               issue_ready;
  logic               pal_we, pal_re;
  logic [IDX_W-1:0]   pal_waddr, pal_raddr;
  logic [COLOR_W-1:0] pal_wdata, pal_rdata;

  // configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q        <= SCALE_RST;
      plane_enable_q <= PLANE_ENABLE_RST;
      plane_count_q  <= PLANE_COUNT_RST;
    end else if (cfg_wr) begin
      case (cfg_reg_e'(paddr[3:2]))
        REG_SCALE:        scale_q        <= pwdata[3:0];
        REG_PLANE_ENABLE: plane_enable_q <= pwdata[7:0];
        REG_PLANE_COUNT:  plane_count_q  <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    case (cfg_reg_e'(paddr[3:2]))
      REG_SCALE:        prdata = CFG_DW'(scale_q);
      REG_PLANE_ENABLE: prdata = CFG_DW'(plane_enable_q);
      REG_PLANE_COUNT:  prdata = CFG_DW'(plane_count_q);
      default:          prdata = '0;
    endcase
  end

  assign cfg.scale        = scale_q;
  assign cfg.plane_enable = plane_enable_q;
  assign cfg.plane_count  = plane_count_q;

  // sequencer
  p2c_seq #(
    .NUM_PLANES (NUM_PLANES),
    .MAX_SCALE  (MAX_SCALE)
  ) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_i          (in_i),
    .cfg_i         (cfg),
    .issue_ready_i (issue_ready),
    .issue_o       (issue),
    .pal_we_o      (pal_we),
    .pal_waddr_o   (pal_waddr),
    .pal_wdata_o   (pal_wdata),
    .pal_re_o      (pal_re),
    .pal_raddr_o   (pal_raddr)
  );

  // palette memory
  p2c_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (PAL_DEPTH)
  ) u_pal (
    .clk_i   (clk_i),
    .we_i    (pal_we),
    .waddr_i (pal_waddr),
    .wdata_i (pal_wdata),
    .re_i    (pal_re),
    .raddr_i (pal_raddr),
    .rdata_o (pal_rdata)
  );

  // result stage
  p2c_out u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .issue_i       (issue),
    .issue_ready_o (issue_ready),
    .rdata_i       (pal_rdata),
    .out_o         (out_o)
  );

endmodule

`default_nettype wire
